>>> hw/rtl/gif_lzw_pixel_decoder_defines.svh
// Assertion macros shared by the GIF LZW decoder RTL.
`ifndef GIF_LZW_PIXEL_DECODER_DEFINES_SVH
`define GIF_LZW_PIXEL_DECODER_DEFINES_SVH
`ifndef SYNTH
`define GLZ_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`define GLZ_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define GLZ_ASSERT_IMPL(label, clk, rstn, ante, cons, msg)
`define GLZ_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif
`endif

>>> hw/rtl/glzw_pkg.sv
// Package with shared types and constants of the GIF LZW decoder.
`default_nettype none
package glzw_pkg;
    localparam int DICT_ENTRIES_DEF  = 4096;
    localparam int MAX_CODE_BITS_DEF = 12;

    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_PULL  = 2'd1;
    localparam logic [1:0] KIND_START = 2'd2;

    localparam logic [2:0] ST_TAKEN   = 3'd0;
    localparam logic [2:0] ST_REFUSED = 3'd1;
    localparam logic [2:0] ST_PIXEL   = 3'd2;
    localparam logic [2:0] ST_NEED    = 3'd3;
    localparam logic [2:0] ST_DRAIN   = 3'd4;
    localparam logic [2:0] ST_DONE    = 3'd5;
    localparam logic [2:0] ST_ERROR   = 3'd6;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] pixel;
        logic       last_pixel;
    } result_t;
endpackage
`default_nettype wire

>>> hw/rtl/glzw_fifo.sv
// Small queue that decouples the item front end from the decoding engine.
`default_nettype none
`include "gif_lzw_pixel_decoder_defines.svh"
module glzw_fifo (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              in_valid,
    output logic             in_ready,
    input  wire glzw_pkg::item_t in_item,
    output logic             out_valid,
    input  wire              out_ready,
    output glzw_pkg::item_t  out_item
);
    glzw_pkg::item_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_item  = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            mem_reg[wp_reg] <= in_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (in_valid && in_ready) begin
                wp_reg <= ~wp_reg;
            end
            if (out_valid && out_ready) begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, in_valid && in_ready}
                       - {1'b0, out_valid && out_ready};
        end
    end

    `GLZ_ASSERT_IMPL(a_cnt_range, aclk, aresetn, 1'b1, cnt_reg != 2'd3, "fifo count overflow")
    `GLZ_ASSERT_NEXT(a_full_block, aclk, aresetn, cnt_reg == 2'd2 && !(out_valid && out_ready),
        cnt_reg == 2'd2, "fifo lost full state")
    `GLZ_ASSERT_NEXT(a_empty_stay, aclk, aresetn, cnt_reg == 2'd0 && !in_valid,
        cnt_reg == 2'd0, "fifo count changed with no transfer")
endmodule
`default_nettype wire

>>> hw/rtl/glzw_engine.sv
// Decoding engine: bit buffer, dictionary walk, string stack and result register.
`default_nettype none
`include "gif_lzw_pixel_decoder_defines.svh"
module glzw_engine #(
    parameter int DICT_ENTRIES  = glzw_pkg::DICT_ENTRIES_DEF,
    parameter int MAX_CODE_BITS = glzw_pkg::MAX_CODE_BITS_DEF
) (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               in_valid,
    output logic              in_ready,
    input  wire glzw_pkg::item_t in_item,
    input  wire  [3:0]        min_code_size,
    input  wire  [15:0]       pixel_limit,
    output logic              out_valid,
    input  wire               out_ready,
    output glzw_pkg::result_t out_res
);
    localparam int AW = $clog2(DICT_ENTRIES);
    localparam int DW = AW + 1;
    localparam logic [12:0] NO_CODE = 13'h1FFF;
    localparam logic [DW-1:0] DICT_N = DW'(DICT_ENTRIES);

    localparam logic [2:0] PH_DECODING = 3'd0;
    localparam logic [2:0] PH_ENDED    = 3'd1;
    localparam logic [2:0] PH_DRAINING = 3'd2;
    localparam logic [2:0] PH_DONE     = 3'd3;
    localparam logic [2:0] PH_ERROR    = 3'd4;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PULL = 3'd1;
    localparam logic [2:0] S_WALK = 3'd2;
    localparam logic [2:0] S_ROOT = 3'd3;
    localparam logic [2:0] S_POP  = 3'd4;

    logic [2:0]  st_reg, st_next;
    logic [19:0] buf_reg, buf_next;
    logic [4:0]  bcnt_reg, bcnt_next;
    logic [7:0]  sub_reg, sub_next;
    logic [3:0]  cw_reg, cw_next;
    logic [12:0] nf_reg, nf_next;
    logic [12:0] prev_reg, prev_next;
    logic [7:0]  fop_reg, fop_next;
    logic [15:0] pe_reg, pe_next;
    logic [2:0]  ph_reg, ph_next;
    logic [DW-1:0] sd_reg, sd_next;
    logic [12:0] code_reg, code_next;
    logic [12:0] walk_reg, walk_next;
    logic        rv_reg, rv_next;
    glzw_pkg::result_t res_reg, res_next;

    logic [7:0]    stack_mem [DICT_ENTRIES];
    logic [11:0]   pre_mem   [DICT_ENTRIES];
    logic [7:0]    suf_mem   [DICT_ENTRIES];
    logic [11:0]   pre_rd_reg;
    logic [7:0]    suf_rd_reg, stk_rd_reg;

    logic          stk_we;
    logic [AW-1:0] stk_wa;
    logic [7:0]    stk_wd;
    logic          dict_we;
    logic [AW-1:0] dict_wa;
    logic [11:0]   pre_wd;
    logic [7:0]    suf_wd;
    logic [AW-1:0] dict_ra, stk_ra;

    logic [3:0]  mcs;
    logic [12:0] clr, eoi;
    logic [12:0] code_w;
    logic [12:0] mask;

    always_comb begin
        if (min_code_size < 4'd2) begin
            mcs = 4'd2;
        end else if (min_code_size > 4'd8) begin
            mcs = 4'd8;
        end else begin
            mcs = min_code_size;
        end
    end
    assign clr    = 13'd1 << mcs;
    assign eoi    = clr + 13'd1;
    assign mask   = (13'd1 << cw_reg) - 13'd1;
    assign code_w = buf_reg[12:0] & mask;

    always_ff @(posedge aclk) begin
        if (stk_we) begin
            stack_mem[stk_wa] <= stk_wd;
        end
        stk_rd_reg <= stack_mem[stk_ra];
    end

    always_ff @(posedge aclk) begin
        if (dict_we) begin
            pre_mem[dict_wa] <= pre_wd;
            suf_mem[dict_wa] <= suf_wd;
        end
        pre_rd_reg <= pre_mem[dict_ra];
        suf_rd_reg <= suf_mem[dict_ra];
    end

    assign in_ready  = (st_reg == S_IDLE) && !rv_reg;
    assign out_valid = rv_reg;
    assign out_res   = res_reg;

    always_comb begin
        st_next   = st_reg;
        buf_next  = buf_reg;
        bcnt_next = bcnt_reg;
        sub_next  = sub_reg;
        cw_next   = cw_reg;
        nf_next   = nf_reg;
        prev_next = prev_reg;
        fop_next  = fop_reg;
        pe_next   = pe_reg;
        ph_next   = ph_reg;
        sd_next   = sd_reg;
        code_next = code_reg;
        walk_next = walk_reg;
        rv_next   = rv_reg && !out_ready;
        res_next  = res_reg;
        stk_we    = 1'b0;
        stk_wa    = sd_reg[AW-1:0];
        stk_wd    = 8'd0;
        dict_we   = 1'b0;
        dict_wa   = nf_reg[AW-1:0];
        pre_wd    = prev_reg[11:0];
        suf_wd    = 8'd0;
        dict_ra   = walk_reg[AW-1:0];
        stk_ra    = sd_reg[AW-1:0] - AW'(1);

        unique case (st_reg)
            S_IDLE: begin
                if (in_valid && in_ready) begin
                    res_next = '0;
                    rv_next  = 1'b1;
                    case (in_item.kind)
                        glzw_pkg::KIND_BYTE: begin
                            res_next.status = glzw_pkg::ST_TAKEN;
                            if (ph_reg == PH_DRAINING) begin
                                if (sub_reg != 8'd0) begin
                                    sub_next = sub_reg - 8'd1;
                                end else if (in_item.data_byte == 8'd0) begin
                                    ph_next = PH_DONE;
                                end else begin
                                    sub_next = in_item.data_byte;
                                end
                            end else if (ph_reg != PH_DECODING
                                         || bcnt_reg >= {1'b0, cw_reg}) begin
                                res_next.status = glzw_pkg::ST_REFUSED;
                            end else if (sub_reg == 8'd0) begin
                                if (in_item.data_byte == 8'd0) begin
                                    ph_next = PH_ENDED;
                                end else begin
                                    sub_next = in_item.data_byte;
                                end
                            end else begin
                                buf_next  = buf_reg
                                            | (20'(in_item.data_byte) << bcnt_reg);
                                bcnt_next = bcnt_reg + 5'd8;
                                sub_next  = sub_reg - 8'd1;
                            end
                        end
                        glzw_pkg::KIND_PULL: begin
                            rv_next = 1'b0;
                            st_next = S_PULL;
                        end
                        glzw_pkg::KIND_START: begin
                            res_next.status = glzw_pkg::ST_TAKEN;
                            buf_next  = '0;
                            bcnt_next = '0;
                            sub_next  = '0;
                            fop_next  = '0;
                            pe_next   = '0;
                            ph_next   = PH_DECODING;
                            sd_next   = '0;
                            cw_next   = mcs + 4'd1;
                            nf_next   = clr + 13'd2;
                            prev_next = NO_CODE;
                        end
                        default: begin
                            res_next.status = glzw_pkg::ST_REFUSED;
                        end
                    endcase
                end
            end
            S_PULL: begin
                rv_next  = 1'b1;
                res_next = '0;
                if (ph_reg == PH_DONE) begin
                    res_next.status = glzw_pkg::ST_DONE;
                    st_next = S_IDLE;
                end else if (ph_reg == PH_ERROR) begin
                    res_next.status = glzw_pkg::ST_ERROR;
                    st_next = S_IDLE;
                end else if (ph_reg == PH_DRAINING) begin
                    res_next.status = glzw_pkg::ST_DRAIN;
                    st_next = S_IDLE;
                end else if (pe_reg >= pixel_limit) begin
                    sd_next = '0;
                    st_next = S_IDLE;
                    if (ph_reg == PH_ENDED) begin
                        ph_next = PH_DONE;
                        res_next.status = glzw_pkg::ST_DONE;
                    end else begin
                        ph_next   = PH_DRAINING;
                        buf_next  = '0;
                        bcnt_next = '0;
                        res_next.status = glzw_pkg::ST_DRAIN;
                    end
                end else if (sd_reg != '0) begin
                    rv_next = 1'b0;
                    st_next = S_POP;
                end else if (ph_reg == PH_ENDED) begin
                    ph_next = PH_DONE;
                    res_next.status = glzw_pkg::ST_DONE;
                    st_next = S_IDLE;
                end else if (bcnt_reg < {1'b0, cw_reg}) begin
                    res_next.status = glzw_pkg::ST_NEED;
                    st_next = S_IDLE;
                end else begin
                    rv_next   = 1'b0;
                    buf_next  = buf_reg >> cw_reg;
                    bcnt_next = bcnt_reg - {1'b0, cw_reg};
                    if (code_w == clr) begin
                        cw_next   = mcs + 4'd1;
                        nf_next   = clr + 13'd2;
                        prev_next = NO_CODE;
                    end else if (code_w == eoi) begin
                        rv_next   = 1'b1;
                        ph_next   = PH_DRAINING;
                        buf_next  = '0;
                        bcnt_next = '0;
                        res_next.status = glzw_pkg::ST_DRAIN;
                        st_next   = S_IDLE;
                    end else if (code_w > nf_reg
                                 || (code_w == nf_reg
                                     && (prev_reg == NO_CODE
                                         || nf_reg >= 13'(DICT_ENTRIES)))) begin
                        rv_next  = 1'b1;
                        sd_next  = '0;
                        ph_next  = PH_ERROR;
                        res_next.status = glzw_pkg::ST_ERROR;
                        st_next  = S_IDLE;
                    end else begin
                        code_next = code_w;
                        if (code_w == nf_reg) begin
                            stk_we    = 1'b1;
                            stk_wa    = '0;
                            stk_wd    = fop_reg;
                            sd_next   = DW'(1);
                            walk_next = prev_reg;
                        end else begin
                            sd_next   = '0;
                            walk_next = code_w;
                        end
                        st_next = S_WALK;
                    end
                end
            end
            S_WALK: begin
                if (walk_reg > eoi && walk_reg < 13'(DICT_ENTRIES)) begin
                    dict_ra = walk_reg[AW-1:0];
                    st_next = S_ROOT;
                end else begin
                    if (sd_reg >= DICT_N) begin
                        rv_next  = 1'b1;
                        res_next = '0;
                        res_next.status = glzw_pkg::ST_ERROR;
                        sd_next  = '0;
                        ph_next  = PH_ERROR;
                        st_next  = S_IDLE;
                    end else begin
                        stk_we  = 1'b1;
                        stk_wd  = walk_reg[7:0];
                        sd_next = sd_reg + DW'(1);
                        fop_next  = walk_reg[7:0];
                        prev_next = code_reg;
                        if (nf_reg < 13'(DICT_ENTRIES) && prev_reg != NO_CODE) begin
                            dict_we = 1'b1;
                            suf_wd  = walk_reg[7:0];
                            nf_next = nf_reg + 13'd1;
                            if ((nf_reg + 13'd1) == (13'd1 << cw_reg)
                                && cw_reg < 4'(MAX_CODE_BITS)) begin
                                cw_next = cw_reg + 4'd1;
                            end
                        end
                        st_next = S_PULL;
                    end
                end
            end
            S_ROOT: begin
                if (sd_reg >= DICT_N) begin
                    rv_next  = 1'b1;
                    res_next = '0;
                    res_next.status = glzw_pkg::ST_ERROR;
                    sd_next  = '0;
                    ph_next  = PH_ERROR;
                    st_next  = S_IDLE;
                end else begin
                    stk_we    = 1'b1;
                    stk_wd    = suf_rd_reg;
                    sd_next   = sd_reg + DW'(1);
                    walk_next = {1'b0, pre_rd_reg};
                    st_next   = S_WALK;
                end
            end
            S_POP: begin
                rv_next  = 1'b1;
                res_next = '0;
                res_next.status = glzw_pkg::ST_PIXEL;
                res_next.pixel  = stk_rd_reg;
                res_next.last_pixel = ((pe_reg + 16'd1) == pixel_limit);
                sd_next  = sd_reg - DW'(1);
                pe_next  = pe_reg + 16'd1;
                st_next  = S_IDLE;
            end
            default: begin
                st_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= S_IDLE;
            buf_reg  <= '0;
            bcnt_reg <= '0;
            sub_reg  <= '0;
            cw_reg   <= 4'd9;
            nf_reg   <= 13'd258;
            prev_reg <= NO_CODE;
            fop_reg  <= '0;
            pe_reg   <= '0;
            ph_reg   <= PH_DECODING;
            sd_reg   <= '0;
            rv_reg   <= 1'b0;
        end else begin
            st_reg   <= st_next;
            buf_reg  <= buf_next;
            bcnt_reg <= bcnt_next;
            sub_reg  <= sub_next;
            cw_reg   <= cw_next;
            nf_reg   <= nf_next;
            prev_reg <= prev_next;
            fop_reg  <= fop_next;
            pe_reg   <= pe_next;
            ph_reg   <= ph_next;
            sd_reg   <= sd_next;
            rv_reg   <= rv_next;
        end
    end

    always_ff @(posedge aclk) begin
        code_reg <= code_next;
        walk_reg <= walk_next;
        res_reg  <= res_next;
    end

    `GLZ_ASSERT_IMPL(a_busy_noready, aclk, aresetn, st_reg != S_IDLE, !in_ready,
        "item taken while engine busy")
    `GLZ_ASSERT_IMPL(a_depth_bound, aclk, aresetn, 1'b1, sd_reg <= DICT_N,
        "stack depth out of range")
    `GLZ_ASSERT_NEXT(a_pop_result, aclk, aresetn, st_reg == S_POP,
        rv_reg && res_reg.status == glzw_pkg::ST_PIXEL, "pop did not give a pixel")
    `GLZ_ASSERT_IMPL(a_bits_bound, aclk, aresetn, 1'b1, bcnt_reg <= 5'd20,
        "bit buffer overfilled")
endmodule
`default_nettype wire

>>> hw/rtl/gif_lzw_pixel_decoder.sv
// Top level of the GIF LZW pixel decoder: stream ports, register port, queue and engine.
// Byte, start and unused items give their result from the engine's idle state; a pull runs
// in S_PULL and, with a pixel already on the stack, pops it in S_POP. A new code is walked
// through S_WALK and S_ROOT, with a registered dictionary read per non-root character, and a
// clear code takes another pass through S_PULL. One item is worked on at a time; the queue
// accepts while a result waits. aresetn is synchronous; no clearing pass is needed.
`default_nettype none
module gif_lzw_pixel_decoder #(
    parameter int DICT_ENTRIES  = glzw_pkg::DICT_ENTRIES_DEF,
    parameter int MAX_CODE_BITS = glzw_pkg::MAX_CODE_BITS_DEF
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // data_byte[7:0]
    input  wire  [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [7:0]  m_tdata,   // pixel[7:0]
    output logic [3:0]  m_tuser,   // status[2:0], last_pixel[3]
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam logic [2:0] ADDR_MCS   = 3'd0;
    localparam logic [2:0] ADDR_LIMIT = 3'd4;

    logic [3:0]  mcs_reg;
    logic [15:0] limit_reg;
    glzw_pkg::item_t   s_item, q_item;
    glzw_pkg::result_t res;
    logic q_valid, q_ready;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mcs_reg   <= 4'd8;
            limit_reg <= 16'd5120;
        end else if (psel && penable && pwrite) begin
            unique case (paddr)
                ADDR_MCS:   mcs_reg   <= pwdata[3:0];
                ADDR_LIMIT: limit_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr)
            ADDR_MCS:   prdata = {28'd0, mcs_reg};
            ADDR_LIMIT: prdata = {16'd0, limit_reg};
            default:    prdata = '0;
        endcase
    end

    assign s_item.kind      = s_tuser;
    assign s_item.data_byte = s_tdata;

    glzw_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (s_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    glzw_engine #(
        .DICT_ENTRIES  (DICT_ENTRIES),
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_engine (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (q_valid),
        .in_ready      (q_ready),
        .in_item       (q_item),
        .min_code_size (mcs_reg),
        .pixel_limit   (limit_reg),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_res       (res)
    );

    assign m_tdata = res.pixel;
    assign m_tuser = {res.last_pixel, res.status};
endmodule
`default_nettype wire

>>> tb/gif_lzw_pixel_decoder_tb.sv
// Self-checking testbench for the GIF LZW pixel decoder with its own decoder predictor.
`timescale 1ns / 1ps
module gif_lzw_pixel_decoder_tb;
    localparam int DICT = 4096;
    localparam int NO_PREV = 'h1FFF;
    localparam int PH_DECODING = 0;
    localparam int PH_ENDED = 1;
    localparam int PH_DRAINING = 2;
    localparam int PH_DONE = 3;
    localparam int PH_ERROR = 4;
    localparam logic [2:0] REG_MIN_CODE_SIZE = 3'd0;
    localparam logic [2:0] REG_PIXEL_LIMIT = 3'd4;
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 20000;
    localparam int ITEM_TARGET = 1050;

    logic aclk, aresetn;
    logic s_tvalid, s_tready, m_tvalid, m_tready;
    logic [7:0] s_tdata, m_tdata;
    logic [1:0] s_tuser;
    logic [3:0] m_tuser;
    logic psel, penable, pwrite, pready;
    logic [2:0] paddr;
    logic [31:0] pwdata, prdata;

    gif_lzw_pixel_decoder dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Decoder state as the predictor sees it.
    int min_size_reg, limit_reg;
    int bit_buf, bit_cnt, block_left, code_bits, free_code, prev_code, prev_first;
    int pixel_count, phase, stack_top;
    logic [7:0] char_stack [DICT];
    int prefix_of [DICT];
    logic [7:0] suffix_of [DICT];

    glzw_pkg::result_t pending_results[$];
    logic [7:0] stream_bytes[$];
    int items_sent, failures, idle_cycles;
    bit calm, hold_long;

    function automatic int eff_size();
        if (min_size_reg < 2) return 2;
        if (min_size_reg > 8) return 8;
        return min_size_reg;
    endfunction

    function automatic void reset_dictionary();
        code_bits = eff_size() + 1;
        free_code = (1 << eff_size()) + 2;
        prev_code = NO_PREV;
    endfunction

    function automatic void begin_image();
        bit_buf = 0; bit_cnt = 0; block_left = 0; prev_first = 0;
        pixel_count = 0; phase = PH_DECODING; stack_top = 0;
        reset_dictionary();
    endfunction

    function automatic bit push_char(int v);
        if (stack_top >= DICT) return 0;
        char_stack[stack_top] = v[7:0];
        stack_top++;
        return 1;
    endfunction

    function automatic bit expand_code(int code);
        int eoi, c, first;
        bit is_new;
        eoi = (1 << eff_size()) + 1;
        is_new = (code == free_code);
        if (code > free_code) return 0;
        if (is_new && (prev_code == NO_PREV || free_code >= DICT)) return 0;
        stack_top = 0;
        if (is_new && !push_char(prev_first)) return 0;
        c = is_new ? prev_code : code;
        while (c > eoi && c < DICT) begin
            if (!push_char(suffix_of[c])) return 0;
            c = prefix_of[c];
        end
        if (!push_char(c)) return 0;
        first = char_stack[stack_top - 1];
        if (free_code < DICT && prev_code != NO_PREV) begin
            prefix_of[free_code] = prev_code;
            suffix_of[free_code] = first[7:0];
            free_code++;
            if (free_code == (1 << code_bits) && code_bits < 12) code_bits++;
        end
        prev_code = code;
        prev_first = first;
        return 1;
    endfunction

    function automatic glzw_pkg::result_t next_pixel();
        glzw_pkg::result_t r;
        int clr, code;
        r = '0;
        clr = 1 << eff_size();
        while (1) begin
            if (phase == PH_DONE) begin r.status = glzw_pkg::ST_DONE; return r; end
            if (phase == PH_ERROR) begin r.status = glzw_pkg::ST_ERROR; return r; end
            if (phase == PH_DRAINING) begin r.status = glzw_pkg::ST_DRAIN; return r; end
            if (pixel_count >= limit_reg) begin
                stack_top = 0;
                if (phase == PH_ENDED) begin
                    phase = PH_DONE; r.status = glzw_pkg::ST_DONE; return r;
                end
                phase = PH_DRAINING; bit_buf = 0; bit_cnt = 0;
                r.status = glzw_pkg::ST_DRAIN;
                return r;
            end
            if (stack_top > 0) begin
                stack_top--;
                pixel_count++;
                r.status = glzw_pkg::ST_PIXEL;
                r.pixel = char_stack[stack_top];
                r.last_pixel = (pixel_count == limit_reg);
                return r;
            end
            if (phase == PH_ENDED) begin
                phase = PH_DONE; r.status = glzw_pkg::ST_DONE; return r;
            end
            if (bit_cnt < code_bits) begin r.status = glzw_pkg::ST_NEED; return r; end
            code = bit_buf & ((1 << code_bits) - 1);
            bit_buf = bit_buf >> code_bits;
            bit_cnt -= code_bits;
            if (code == clr) begin
                reset_dictionary();
            end else if (code == clr + 1) begin
                phase = PH_DRAINING; bit_buf = 0; bit_cnt = 0;
                r.status = glzw_pkg::ST_DRAIN;
                return r;
            end else if (!expand_code(code)) begin
                stack_top = 0; phase = PH_ERROR;
                r.status = glzw_pkg::ST_ERROR;
                return r;
            end
        end
    endfunction

    function automatic logic [2:0] take_byte(int b);
        if (phase == PH_DRAINING) begin
            if (block_left > 0) block_left--;
            else if (b == 0) phase = PH_DONE;
            else block_left = b;
            return glzw_pkg::ST_TAKEN;
        end
        if (phase != PH_DECODING || bit_cnt >= code_bits) return glzw_pkg::ST_REFUSED;
        if (block_left == 0) begin
            if (b == 0) phase = PH_ENDED;
            else block_left = b;
            return glzw_pkg::ST_TAKEN;
        end
        bit_buf = (bit_buf | (b << bit_cnt)) & 'hFFFFF;
        bit_cnt += 8;
        block_left--;
        return glzw_pkg::ST_TAKEN;
    endfunction

    function automatic glzw_pkg::result_t decode_item(logic [1:0] kind, logic [7:0] data);
        glzw_pkg::result_t r;
        r = '0;
        case (kind)
            glzw_pkg::KIND_BYTE: r.status = take_byte(data);
            glzw_pkg::KIND_PULL: r = next_pixel();
            glzw_pkg::KIND_START: begin begin_image(); r.status = glzw_pkg::ST_TAKEN; end
            default: r.status = glzw_pkg::ST_REFUSED;
        endcase
        return r;
    endfunction

    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    // Result checker.
    always @(posedge aclk) begin
        glzw_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result transfer status=%0d", m_tuser[2:0]);
                failures++;
            end else begin
                want = pending_results.pop_front();
                if (m_tuser[2:0] !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_tuser[2:0]);
                    failures++;
                end
                if (m_tdata !== want.pixel) begin
                    $error("pixel: expected %0d, got %0d", want.pixel, m_tdata);
                    failures++;
                end
                if (m_tuser[3] !== want.last_pixel) begin
                    $error("last_pixel: expected %0d, got %0d", want.last_pixel, m_tuser[3]);
                    failures++;
                end
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result receiver with random stalls and one long hold-off.
    initial begin
        m_tready = 0;
        forever begin
            @(negedge aclk);
            if (hold_long) begin
                m_tready <= 0;
                repeat (300) @(negedge aclk);
                hold_long = 0;
                m_tready <= 1;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                m_tready <= 0;
                repeat ($urandom_range(0, 7)) @(negedge aclk);
            end else begin
                m_tready <= 1;
            end
        end
    end

    task automatic send_item(logic [1:0] kind, logic [7:0] data);
        @(negedge aclk);
        if (!calm && $urandom_range(0, 6) == 0) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 8)) @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tuser <= kind;
        s_tdata <= data;
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(decode_item(kind, data));
        items_sent++;
    endtask

    task automatic wait_results();
        @(negedge aclk);
        s_tvalid <= 0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] addr, int value);
        @(negedge aclk);
        psel <= 1; pwrite <= 1; paddr <= addr; pwdata <= value; penable <= 0;
        @(negedge aclk);
        penable <= 1;
        @(posedge aclk);
        if (addr == REG_MIN_CODE_SIZE) min_size_reg = value & 'hF;
        else limit_reg = value & 'hFFFF;
        @(negedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    // Encodes a random code sequence into sub-blocks, mirroring the code width growth.
    // mode 0 normal, 1 with a code beyond the next free entry, 2 roots only, 3 no EOI.
    task automatic build_stream(int size_reg, int ncodes, int mode);
        int sz, clr, nf, w, code, r, acc, nacc, idx, len;
        bit has_prev;
        logic [7:0] packed_bytes[$];
        sz = size_reg < 2 ? 2 : (size_reg > 8 ? 8 : size_reg);
        clr = 1 << sz;
        nf = clr + 2; w = sz + 1; has_prev = 0; acc = 0; nacc = 0;
        for (int i = -1; i <= ncodes; i++) begin
            r = $urandom_range(0, 99);
            if (i == -1 || (i < ncodes && mode != 2 && r < 4)) begin
                code = (i == -1 && mode != 2 && r < 10) ? -1 : clr;
            end else if (i == ncodes) begin
                code = (mode == 3) ? -1 : clr + 1;
            end else if (mode == 1 && r < 12 && nf + 1 < (1 << w)) begin
                code = $urandom_range(nf + 1, (1 << w) - 1);
            end else if (mode == 2 || !has_prev || r < 50) begin
                code = $urandom_range(0, clr - 1);
            end else if (r < 80 && nf > clr + 2) begin
                code = $urandom_range(clr + 2, nf - 1);
            end else if (nf < DICT) begin
                code = nf;
            end else begin
                code = $urandom_range(0, clr - 1);
            end
            if (code >= 0) begin
                acc = acc | (code << nacc);
                nacc += w;
                while (nacc >= 8) begin
                    packed_bytes.push_back(acc[7:0]);
                    acc = acc >> 8; nacc -= 8;
                end
                if (code == clr) begin
                    nf = clr + 2; w = sz + 1; has_prev = 0;
                end else if (code != clr + 1) begin
                    if (has_prev && nf < DICT) begin
                        nf++;
                        if (nf == (1 << w) && w < 12) w++;
                    end
                    has_prev = 1;
                end
            end
        end
        if (nacc > 0) packed_bytes.push_back(acc[7:0]);
        stream_bytes.delete();
        idx = 0;
        while (idx < packed_bytes.size()) begin
            len = ($urandom_range(0, 9) == 0) ? 255 : $urandom_range(1, 16);
            if (len > packed_bytes.size() - idx) len = packed_bytes.size() - idx;
            stream_bytes.push_back(8'(len));
            repeat (len) begin
                stream_bytes.push_back(packed_bytes[idx]);
                idx++;
            end
        end
        stream_bytes.push_back(8'd0);
    endtask

    // Runs one image; lower_at > 0 lowers the pixel limit after that many stream bytes.
    task automatic run_image(int size_reg, int limit, int ncodes, int mode, int lower_at);
        int idx, guard;
        bit room;
        wait_results();
        write_reg(REG_MIN_CODE_SIZE, size_reg);
        write_reg(REG_PIXEL_LIMIT, limit);
        build_stream(size_reg, ncodes, mode);
        send_item(glzw_pkg::KIND_START, 8'($urandom));
        idx = 0; guard = 0;
        while (idx < stream_bytes.size() && guard < 100000) begin
            guard++;
            if (phase == PH_DONE || phase == PH_ERROR || phase == PH_ENDED) break;
            if (lower_at > 0 && idx == lower_at) begin
                wait_results();
                write_reg(REG_PIXEL_LIMIT, $urandom_range(0, pixel_count));
                lower_at = 0;
            end
            room = (phase == PH_DRAINING) || (phase == PH_DECODING && bit_cnt < code_bits);
            if (room && $urandom_range(0, 3) != 0) begin
                send_item(glzw_pkg::KIND_BYTE, stream_bytes[idx]);
                idx++;
            end else if (!room && $urandom_range(0, 30) == 0) begin
                send_item(glzw_pkg::KIND_BYTE, 8'($urandom));
            end else begin
                send_item(glzw_pkg::KIND_PULL, 8'($urandom));
            end
        end
        while (phase != PH_DONE && phase != PH_ERROR && guard < 100000) begin
            guard++;
            send_item(glzw_pkg::KIND_PULL, 8'($urandom));
        end
        send_item(glzw_pkg::KIND_PULL, 8'($urandom));
        send_item(glzw_pkg::KIND_BYTE, 8'($urandom));
    endtask

    task automatic test_edge_items();
        send_item(KIND_UNUSED, 8'hFF);
        send_item(glzw_pkg::KIND_PULL, 8'h00);
        send_item(glzw_pkg::KIND_BYTE, 8'd1);
        send_item(glzw_pkg::KIND_PULL, 8'hFF);
        send_item(glzw_pkg::KIND_BYTE, 8'hFF);
        send_item(glzw_pkg::KIND_PULL, 8'h00);
        send_item(glzw_pkg::KIND_BYTE, 8'h00);
        send_item(glzw_pkg::KIND_BYTE, 8'h00);
        send_item(glzw_pkg::KIND_PULL, 8'h00);
        send_item(glzw_pkg::KIND_PULL, 8'h00);
        send_item(glzw_pkg::KIND_BYTE, 8'hAA);
        send_item(glzw_pkg::KIND_START, 8'h55);
        send_item(glzw_pkg::KIND_BYTE, 8'h00);
        send_item(glzw_pkg::KIND_PULL, 8'h00);
    endtask

    task automatic test_code_sizes();
        run_image(2, 65535, 12, 0, 0);
        run_image(8, 1, 6, 0, 0);
        run_image(0, 40, 8, 0, 0);
        run_image(15, 65535, 8, 3, 0);
        run_image(5, 65535, 8, 1, 0);
    endtask

    task automatic test_limit_lowered();
        run_image(3, 65535, 30, 0, 12);
    endtask

    task automatic test_dictionary_growth();
        run_image(2, 65535, 200, 2, 0);
    endtask

    task automatic test_backpressure();
        wait_results();
        hold_long = 1;
        run_image(4, 65535, 20, 0, 0);
    endtask

    task automatic test_random_images();
        int limit;
        do begin
            if (items_sent > ITEM_TARGET * 85 / 100) calm = 1;
            case ($urandom_range(0, 3))
                0: limit = $urandom_range(1, 30);
                1: limit = 65535;
                default: limit = $urandom_range(1, 400);
            endcase
            run_image($urandom_range(0, 15), limit, $urandom_range(4, 30),
                      $urandom_range(0, 9) == 0 ? 1 : ($urandom_range(0, 9) == 0 ? 3 : 0), 0);
        end while (items_sent < ITEM_TARGET);
    endtask

    initial begin
        aresetn = 0;
        s_tvalid = 0; s_tdata = 0; s_tuser = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        items_sent = 0; failures = 0; idle_cycles = 0; calm = 0; hold_long = 0;
        min_size_reg = 8; limit_reg = 5120;
        for (int i = 0; i < DICT; i++) begin
            char_stack[i] = 0; prefix_of[i] = 0; suffix_of[i] = 0;
        end
        begin_image();
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;
        test_edge_items();
        test_code_sizes();
        test_limit_lowered();
        test_backpressure();
        test_dictionary_growth();
        test_random_images();
        wait_results();
        if (failures == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

>>> gif_lzw_pixel_decoder.f
+incdir+hw/rtl
hw/rtl/glzw_pkg.sv
hw/rtl/glzw_fifo.sv
hw/rtl/glzw_engine.sv
hw/rtl/gif_lzw_pixel_decoder.sv
tb/gif_lzw_pixel_decoder_tb.sv
